### hw/rtl/csk_pkg.sv
// Shared types and constants for the constant-state Kalman filter.
// Used by csk_ctrl, csk_dpath and the top level; depends on nothing.
package csk_pkg;

  // Field widths
  localparam int CHAN_W   = 2;
  localparam int DATA_W   = 32;
  localparam int CFG_IDX_W = 1;

  // Q16.16 one, reset variance
  localparam logic [DATA_W-1:0] Q_ONE = 32'h0001_0000;

  // Gain is at most 1.0 in Q16.16, so 17 bits
  localparam int GAIN_W   = 17;
  localparam int DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_NOISE  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_PRED,
    ST_DIV,
    ST_MUL,
    ST_POST
  } csk_state_t;

  typedef struct packed {
    logic cap;       // take the input word
    logic rd;        // read channel state
    logic pred;      // predict variance, set up divider
    logic div_step;  // one quotient bit
    logic mul;       // both products
    logic post;      // write back and load the result word
  } csk_cmd_t;

  typedef struct packed {
    logic div_last;
  } csk_sts_t;

endpackage

### hw/rtl/constant_state_kalman_filter.sv
// Constant-state Kalman filter over independent scalar channels, Q16.16.
// Instantiates csk_ctrl and csk_dpath; uses csk_pkg.
//
// Each input word carries a channel and a signed Q16.16 sample; the block runs
// one predict/update step on that channel's estimate and variance and returns
// one output word with the channel, the new estimate and the new variance.
// One word is in flight at a time. After acceptance the block reads the channel
// state, predicts the variance, runs the bit-serial gain divider, computes both
// products, and writes back while posting the result. The next word can be
// accepted in the cycle after the post, not before. A new word is accepted
// while the previous result still waits in the output register; its write-back
// then stalls until that result is taken. Channels at or above CHANNELS
// report estimate 0 and variance 0 and change nothing. The user must write the
// configuration registers (index 0 process noise, index 1 sensor noise) only
// while idle; the block itself does not enforce this.
module constant_state_kalman_filter
  import csk_pkg::*;
#(
  parameter int CHANNELS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input word
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [39:0]          in_tdata,   // [1:0] channel, [33:2] sample, zero pad
  // output word
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [71:0]          out_tdata,  // [1:0] channel_out, [33:2] estimate,
                                           // [65:34] variance, zero pad
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [DATA_W-1:0]    cfg_wdata
);

  csk_cmd_t                 cmd;
  csk_sts_t                 sts;
  logic [CHAN_W-1:0]        res_channel;
  logic signed [DATA_W-1:0] res_estimate;
  logic [DATA_W-1:0]        res_variance;

  csk_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  csk_dpath #(
    .CHANNELS (CHANNELS)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .in_channel   (in_tdata[1:0]),
    .in_sample    (in_tdata[33:2]),
    .out_channel  (res_channel),
    .out_estimate (res_estimate),
    .out_variance (res_variance)
  );

  // Pack the result word
  assign out_tdata = {6'b0, res_variance, res_estimate, res_channel};

endmodule

### hw/rtl/csk_ctrl.sv
// Sequencer for the Kalman filter step: handshakes and datapath commands.
// Depends on csk_pkg.
module csk_ctrl
  import csk_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output csk_cmd_t cmd,
  input  csk_sts_t sts
);

  csk_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.cap   = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_PRED;
      end
      ST_PRED: begin
        cmd.pred  = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_POST;
      end
      ST_POST: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          cmd.post  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Set on a new result, drop when taken
  always_comb begin
    priority if (cmd.post) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

### hw/rtl/csk_dpath.sv
// Datapath of the Kalman filter: config registers, channel state memory,
// radix-2 gain divider, two multipliers and rounding/saturation. Uses csk_pkg.
module csk_dpath
  import csk_pkg::*;
#(
  parameter int CHANNELS = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  csk_cmd_t                 cmd,
  output csk_sts_t                 sts,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_idx,
  input  logic [DATA_W-1:0]        cfg_wdata,
  input  logic [CHAN_W-1:0]        in_channel,
  input  logic signed [DATA_W-1:0] in_sample,
  output logic [CHAN_W-1:0]        out_channel,
  output logic signed [DATA_W-1:0] out_estimate,
  output logic [DATA_W-1:0]        out_variance
);

  localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Configuration
  logic [DATA_W-1:0] process_noise_r, sensor_noise_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      process_noise_r <= Q_ONE;
      sensor_noise_r  <= Q_ONE;
    end else if (cfg_we) begin
      if (cfg_idx == REG_PROCESS_NOISE) begin
        process_noise_r <= cfg_wdata;
      end else if (cfg_idx == REG_SENSOR_NOISE) begin
        sensor_noise_r <= cfg_wdata;
      end
    end
  end

  // Captured input word
  logic [CHAN_W-1:0]        chan_r;
  logic signed [DATA_W-1:0] sample_r;
  logic [ADDR_W-1:0]        addr;
  logic                     chan_ok;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      chan_r   <= in_channel;
      sample_r <= in_sample;
    end
  end

  assign addr    = ADDR_W'(chan_r);
  assign chan_ok = (32'(chan_r) < 32'(CHANNELS));

  // Channel state memory; entries not yet written read as reset values
  logic signed [DATA_W-1:0] est_mem [CHANNELS];
  logic [DATA_W-1:0]        var_mem [CHANNELS];
  logic [CHANNELS-1:0]      vld_r;
  logic signed [DATA_W-1:0] rd_est_r;
  logic [DATA_W-1:0]        rd_var_r;
  logic                     rd_vld_r;
  logic signed [DATA_W-1:0] est_new;
  logic [DATA_W-1:0]        var_new;

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_est_r <= est_mem[addr];
      rd_var_r <= var_mem[addr];
      rd_vld_r <= vld_r[addr];
    end
    if (cmd.post && chan_ok) begin
      est_mem[addr] <= est_new;
      var_mem[addr] <= var_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.post && chan_ok) begin
      vld_r[addr] <= 1'b1;
    end
  end

  // Predict: P + process_noise saturating, divisor at 33 bits
  logic [DATA_W-1:0]        cur_var;
  logic [DATA_W:0]          p_sum;
  logic [DATA_W-1:0]        p_pred;
  logic [DATA_W:0]          denom;
  logic [DATA_W-1:0]        p_r;
  logic signed [DATA_W-1:0] est_r;
  logic [DATA_W:0]          denom_r;
  logic                     zero_r;

  assign cur_var = rd_vld_r ? rd_var_r : Q_ONE;
  assign p_sum   = {1'b0, cur_var} + {1'b0, process_noise_r};
  assign p_pred  = p_sum[DATA_W] ? '1 : p_sum[DATA_W-1:0];
  assign denom   = {1'b0, p_pred} + {1'b0, sensor_noise_r};

  always_ff @(posedge clk) begin
    if (cmd.pred) begin
      p_r     <= p_pred;
      est_r   <= rd_vld_r ? rd_est_r : '0;
      denom_r <= denom;
      zero_r  <= (denom == '0);
    end
  end

  // Gain divider: quotient of (P << 16) / denom, one bit a cycle.
  // P/2 is below the divisor, so only the low 17 quotient bits are live.
  logic [DATA_W:0]          rem_r;
  logic [GAIN_W-1:0]        dsh_r;
  logic [GAIN_W-1:0]        q_r;
  logic [DIV_CNT_W-1:0]     cnt_r;
  logic [DATA_W+1:0]        trial;
  logic                     fits;

  assign trial = {rem_r, dsh_r[GAIN_W-1]};
  assign fits  = (trial >= {1'b0, denom_r});

  always_ff @(posedge clk) begin
    if (cmd.pred) begin
      rem_r <= {2'b00, p_pred[DATA_W-1:1]};
      dsh_r <= {p_pred[0], {(GAIN_W-1){1'b0}}};
      q_r   <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      // remainder stays below the 33-bit divisor
      rem_r <= fits ? (DATA_W+1)'(trial - {1'b0, denom_r})
                    : trial[DATA_W:0];
      dsh_r <= {dsh_r[GAIN_W-2:0], 1'b0};
      q_r   <= {q_r[GAIN_W-2:0], fits};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign sts.div_last = (cnt_r == DIV_LAST);

  // Products: gain * innovation, P * (1 - gain)
  logic [GAIN_W-1:0]          gain;
  logic [GAIN_W-1:0]          one_minus;
  logic signed [DATA_W:0]     diff;
  logic signed [DATA_W+GAIN_W+1:0] prod_e_r;
  logic [DATA_W+GAIN_W-1:0]   prod_v_r;

  assign gain      = zero_r ? '0 : q_r;
  assign one_minus = GAIN_W'(Q_ONE) - gain;
  assign diff      = (DATA_W+1)'(sample_r) - (DATA_W+1)'(est_r);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_e_r <= $signed({1'b0, gain}) * diff;
      prod_v_r <= p_r * one_minus;
    end
  end

  // Round half up, add, saturate
  localparam int PE_W = DATA_W + GAIN_W + 2;
  localparam int PV_W = DATA_W + GAIN_W + 1;
  logic signed [PE_W-1:0] corr;
  logic signed [PE_W-1:0] est_sum;
  logic [PV_W-1:0]        var_rnd;
  logic signed [PE_W-1:0] est_max, est_min;

  assign est_max = PE_W'(33'sh0_7FFF_FFFF);
  assign est_min = -PE_W'(33'sh0_8000_0000);
  assign corr    = (prod_e_r + PE_W'(32768)) >>> 16;
  assign est_sum = PE_W'(est_r) + corr;
  assign var_rnd = (PV_W'(prod_v_r) + PV_W'(32768)) >> 16;

  always_comb begin
    priority if (est_sum > est_max) begin
      est_new = 32'sh7FFF_FFFF;
    end else if (est_sum < est_min) begin
      est_new = 32'sh8000_0000;
    end else begin
      est_new = est_sum[DATA_W-1:0];
    end
  end

  // Never above P, so the low 32 bits hold it
  assign var_new = var_rnd[DATA_W-1:0];

  // Result word register
  always_ff @(posedge clk) begin
    if (cmd.post) begin
      out_channel  <= chan_r;
      out_estimate <= chan_ok ? est_new : '0;
      out_variance <= chan_ok ? var_new : '0;
    end
  end

endmodule

### hw/rtl/csk_checker.sv
// Port-level checks for constant_state_kalman_filter, bound to the top level.
// Depends only on the handshake, data and cfg_we ports of the top level.
module csk_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic        cfg_we
);

  // One word at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a word is in flight");

  // Posting a result returns the block to idle
  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("result posted while still busy");

  // No result out of reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result word changed");

  // Write registers only while no word is being processed
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> in_tready)
    else $error("register written while a word is in flight");

endmodule

bind constant_state_kalman_filter csk_checker u_csk_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_we     (cfg_we)
);

### tb/constant_state_kalman_filter_tb.sv
// Self-checking testbench for constant_state_kalman_filter.
// Drives sample words and register writes, predicts every output word with its own
// Q16.16 filter model and compares field by field. Uses csk_pkg and the RTL only.
`timescale 1ns / 1ps

module constant_state_kalman_filter_tb;
  import csk_pkg::*;

  localparam int NUM_CH       = 4;
  localparam int RESET_CYCLES = 8;
  localparam int SETTLE_CYCLES = 40;    // wait after each drain for the block to go idle
  localparam int STALL_LIMIT  = 4000;
  localparam int RAND_PHASES  = 11;
  localparam int WORDS_PER_PHASE = 150;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [CHAN_W-1:0]        chan;
    logic signed [DATA_W-1:0] estimate;
    logic [DATA_W-1:0]        variance;
  } kf_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [39:0]       in_tdata = '0;    // [1:0] channel, [33:2] sample, zero pad
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [71:0]       out_tdata;        // [1:0] channel_out, [33:2] estimate,
                                       // [65:34] variance, zero pad
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = REG_PROCESS_NOISE;
  logic [DATA_W-1:0]    cfg_wdata = '0;

  // Filter model state and register copies
  logic signed [DATA_W-1:0] est_mem [NUM_CH] = '{default: '0};
  logic [DATA_W-1:0]        var_mem [NUM_CH] = '{default: Q_ONE};
  logic [DATA_W-1:0]        proc_noise = Q_ONE;
  logic [DATA_W-1:0]        sens_noise = Q_ONE;

  logic [39:0] sample_q [$];       // sample words waiting to be driven
  kf_word_t    filter_out_q [$];   // predicted output words, oldest first

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int err_count = 0;
  int stall_cycles = 0;
  kf_word_t seen_word;

  constant_state_kalman_filter #(.CHANNELS(NUM_CH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One predict/update step of the scalar filter on the model state
  function automatic kf_word_t kf_step(input logic [CHAN_W-1:0] ch,
                                       input logic signed [DATA_W-1:0] z);
    kf_word_t res;
    longint pv, dv, gain, diff, est;
    res.chan = ch;
    res.estimate = '0;
    res.variance = '0;
    if (ch >= NUM_CH) return res;
    // predict variance, saturating at 32 bits
    pv = longint'(var_mem[ch]);
    pv = pv + longint'(proc_noise);
    if (pv > 64'hFFFF_FFFF) pv = 64'hFFFF_FFFF;
    // gain in Q16.16, zero when the divisor is zero
    dv = pv + longint'(sens_noise);
    gain = (dv == 0) ? 0 : (pv <<< 16) / dv;
    // correct the estimate, round half up, saturate to signed 32 bits
    diff = longint'(z) - longint'(est_mem[ch]);
    est = longint'(est_mem[ch]) + ((gain * diff + 32768) >>> 16);
    if (est > 64'sh7FFF_FFFF) est = 64'sh7FFF_FFFF;
    if (est < -64'sh8000_0000) est = -64'sh8000_0000;
    est_mem[ch] = est[31:0];
    // shrink variance
    pv = (pv * (65536 - gain) + 32768) >>> 16;
    if (pv > 64'hFFFF_FFFF) pv = 64'hFFFF_FFFF;
    var_mem[ch] = pv[31:0];
    res.estimate = est_mem[ch];
    res.variance = var_mem[ch];
    return res;
  endfunction

  task automatic flag_error(input string what, input kf_word_t want, input kf_word_t got);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("%0t: %s: want ch=%0d est=%h var=%h, got ch=%0d est=%h var=%h",
               $realtime, what, want.chan, want.estimate, want.variance,
               got.chan, got.estimate, got.variance);
  endtask

  // Driver: predict on acceptance, then load the next word or drop valid
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        filter_out_q.push_back(kf_step(in_tdata[1:0], in_tdata[33:2]));
      if (!in_tvalid || in_tready) begin
        if (sample_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_tdata <= sample_q.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver backpressure
  always @(posedge clk) begin
    out_tready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Monitor: compare each output word with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_word.chan = out_tdata[1:0];
      seen_word.estimate = out_tdata[33:2];
      seen_word.variance = out_tdata[65:34];
      if (filter_out_q.size() == 0)
        flag_error("unexpected word", '0, seen_word);
      else if (filter_out_q[0] != seen_word)
        flag_error("mismatch", filter_out_q.pop_front(), seen_word);
      else
        void'(filter_out_q.pop_front());
    end
  end

  // Watchdog: end the run if no word moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic push_sample(input logic [CHAN_W-1:0] ch, input logic [DATA_W-1:0] z);
    sample_q.push_back({6'b0, z, ch});
  endtask

  // Hold until every word is out and the block has gone idle
  task automatic drain();
    while (sample_q.size() != 0 || in_tvalid || filter_out_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    if (idx == REG_PROCESS_NOISE) proc_noise = val;
    else if (idx == REG_SENSOR_NOISE) sens_noise = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] pick_noise();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2: return Q_ONE;
      3: return $urandom();
      4: return $urandom_range(0, 32'h0004_0000);
      default: return $urandom_range(32'h0100_0000, 32'h8000_0000);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom();
      5, 6, 7: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      8: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'h0003_0000;   // steady reading, lets the filter converge
    endcase
  endfunction

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 15;
    recv_idle_pct = 85;

    // Directed: sample extremes on every channel under reset noise values
    push_sample(2'd0, 32'h7FFF_FFFF);
    push_sample(2'd1, 32'h8000_0000);
    push_sample(2'd2, 32'h0000_0000);
    push_sample(2'd3, 32'hFFFF_FFFF);
    push_sample(2'd0, 32'h8000_0000);
    push_sample(2'd1, 32'h7FFF_FFFF);
    push_sample(2'd2, 32'h0000_0001);
    push_sample(2'd3, 32'h0001_0000);
    drain();

    // No noise at all: first step drives variance to zero, second hits zero divisor
    write_reg(REG_PROCESS_NOISE, 32'h0);
    write_reg(REG_SENSOR_NOISE, 32'h0);
    push_sample(2'd0, 32'h1234_5678);
    push_sample(2'd0, 32'h7FFF_FFFF);
    push_sample(2'd1, 32'h8000_0000);
    push_sample(2'd1, 32'hFFFF_FFFB);
    drain();

    // Largest process noise: predicted variance saturates
    write_reg(REG_PROCESS_NOISE, 32'hFFFF_FFFF);
    push_sample(2'd0, 32'h7FFF_FFFF);
    push_sample(2'd2, 32'h8000_0000);
    push_sample(2'd3, 32'h5555_5555);
    push_sample(2'd1, 32'hAAAA_AAAA);
    drain();

    // Both noises at full scale
    write_reg(REG_SENSOR_NOISE, 32'hFFFF_FFFF);
    push_sample(2'd0, 32'h8000_0000);
    push_sample(2'd1, 32'h7FFF_FFFF);
    push_sample(2'd2, 32'h0000_0000);
    push_sample(2'd3, 32'h0000_FFFF);
    drain();

    // Random phases, each with its own noise setting, under one of three idling patterns
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph < 4) begin
        send_idle_pct = 15;
        recv_idle_pct = 85;
      end else if (ph < 8) begin
        send_idle_pct = 85;
        recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        0: begin
          write_reg(REG_PROCESS_NOISE, 32'h0);
          write_reg(REG_SENSOR_NOISE, 32'hFFFF_FFFF);
        end
        1: begin
          write_reg(REG_PROCESS_NOISE, 32'hFFFF_FFFF);
          write_reg(REG_SENSOR_NOISE, 32'h0);
        end
        default: begin
          write_reg(REG_PROCESS_NOISE, pick_noise());
          write_reg(REG_SENSOR_NOISE, pick_noise());
        end
      endcase
      for (int n = 0; n < WORDS_PER_PHASE; n++)
        push_sample(CHAN_W'($urandom_range(0, NUM_CH - 1)), pick_sample());
      drain();
    end

    if (err_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

### sim.f
hw/rtl/csk_pkg.sv
hw/rtl/csk_ctrl.sv
hw/rtl/csk_dpath.sv
hw/rtl/constant_state_kalman_filter.sv
hw/rtl/csk_checker.sv
tb/constant_state_kalman_filter_tb.sv
